### rtl/ssp_pkg.sv
// ssp_pkg: shared constants, register indexes and word types of the sprite projection unit
// no dependencies; imported by every module of the block
`default_nettype none

package ssp_pkg;

  localparam int SCREEN_BITS   = 12;
  localparam int POS_FRAC_BITS = 8;
  localparam int DEPTH_SHIFT   = 30 - POS_FRAC_BITS;

  localparam int CFG_BITS  = SCREEN_BITS + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);

  localparam int DIFF_W = 17;
  localparam int PROD_W = 33;
  localparam int DET_W  = 33;
  localparam int SUM_W  = 34;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int LIM_W = 20;
  localparam logic signed [LIM_W-1:0] ROW_MAX = LIM_W'((1 << SCREEN_BITS) - 1);
  localparam logic signed [LIM_W-1:0] COL_MAX = LIM_W'((1 << (SCREEN_BITS + 1)) - 1);

  typedef struct packed {
    logic        [15:0] sprite_x;
    logic        [15:0] sprite_y;
    logic        [15:0] player_x;
    logic        [15:0] player_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0]            depth;
    logic signed [15:0]            center_column;
    logic        [15:0]            sprite_height;
    logic        [15:0]            sprite_width;
    logic        [SCREEN_BITS-1:0] top_row;
    logic        [SCREEN_BITS-1:0] bottom_row;
    logic        [SCREEN_BITS:0]   left_column;
    logic        [SCREEN_BITS:0]   right_column;
    logic        [1:0]             clipped_edges;
    logic                          behind;
  } result_t;

  typedef struct packed {
    logic signed [DET_W-1:0] det;
    logic signed [SUM_W-1:0] numx;
    logic signed [SUM_W-1:0] numy;
  } proj_t;

endpackage

`default_nettype wire

### rtl/sprite_screen_projection_unit.sv
// sprite_screen_projection_unit: top level of the raycaster sprite projection block
// depends on ssp_pkg, ssp_front, ssp_queue, ssp_back
//
// One sprite word can be started on every clock cycle while busy is low. Each word
// passes through three front stages, the queue, two sign stages, a 33-stage
// restoring divider for depth and centre column, one saturation stage, a load stage
// and a 17-stage divider pair for height and width, and the clipping stage. done is
// high for exactly one cycle with the result word and cannot be held off; busy only
// rises if the queue fills. Screen size writes are taken at any time through the cfg
// channel and must happen while no word is in flight.
`default_nettype none

module sprite_screen_projection_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire ssp_pkg::in_word_t             in_word,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ssp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ssp_pkg::CFG_BITS-1:0]  cfg_data,
  output logic                               done,
  output ssp_pkg::result_t                   result
);
  import ssp_pkg::*;

  logic [CFG_BITS-1:0] screen_width, screen_height;
  logic  push, full, q_valid, pop;
  proj_t proj, q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  ssp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_word (in_word),
    .full    (full),
    .push    (push),
    .proj    (proj)
  );

  ssp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (proj),
    .full   (full),
    .rvalid (q_valid),
    .pop    (pop),
    .rdata  (q_data)
  );

  ssp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (pop),
    .done          (done),
    .result        (result)
  );

`ifndef SYNTHESIS
  a_front_depth_positive: assert property (@(posedge clk) disable iff (rst)
    done && !result.behind |-> result.depth > 0)
    else $error("visible sprite without positive depth");

  a_behind_sizes: assert property (@(posedge clk) disable iff (rst)
    done && result.behind |-> result.sprite_height == 16'hFFFF &&
                              result.sprite_width == 16'hFFFF)
    else $error("behind sprite without saturated sizes");

  a_clip_count: assert property (@(posedge clk) disable iff (rst)
    done |-> result.clipped_edges != 2'd3)
    else $error("clipped edge count out of range");

  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");
`endif

endmodule

`default_nettype wire

### rtl/ssp_front.sv
// ssp_front: accepts words, forms position deltas, camera products and the three sums
// depends on ssp_pkg; feeds ssp_queue
`default_nettype none

module ssp_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire ssp_pkg::in_word_t in_word,
  input  wire logic             full,
  output logic                  push,
  output ssp_pkg::proj_t        proj
);
  import ssp_pkg::*;

  logic adv;
  logic accept;
  logic v1, v2, v3;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;

  logic signed [PROD_W-1:0] e_dir_x, e_dir_y, e_plane_x, e_plane_y, e_dx, e_dy;
  logic signed [PROD_W-1:0] p_det_a, p_det_b, p_nx_a, p_nx_b, p_ny_a, p_ny_b;

  assign adv    = !(v3 && full);
  assign busy   = !adv;
  assign accept = start && adv;
  assign push   = v3 && !full;

  always_comb begin
    e_dir_x   = PROD_W'(dir_x);
    e_dir_y   = PROD_W'(dir_y);
    e_plane_x = PROD_W'(plane_x);
    e_plane_y = PROD_W'(plane_y);
    e_dx      = PROD_W'(dx);
    e_dy      = PROD_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx      <= DIFF_W'(in_word.sprite_x) - DIFF_W'(in_word.player_x);
      dy      <= DIFF_W'(in_word.sprite_y) - DIFF_W'(in_word.player_y);
      dir_x   <= in_word.dir_x;
      dir_y   <= in_word.dir_y;
      plane_x <= in_word.plane_x;
      plane_y <= in_word.plane_y;

      p_det_a <= e_plane_x * e_dir_y;
      p_det_b <= e_dir_x * e_plane_y;
      p_nx_a  <= e_dir_y * e_dx;
      p_nx_b  <= e_dir_x * e_dy;
      p_ny_a  <= e_plane_x * e_dy;
      p_ny_b  <= e_plane_y * e_dx;

      proj.det  <= DET_W'(p_det_a) - DET_W'(p_det_b);
      proj.numx <= SUM_W'(p_nx_a) - SUM_W'(p_nx_b);
      proj.numy <= SUM_W'(p_ny_a) - SUM_W'(p_ny_b);
    end
  end

endmodule

`default_nettype wire

### rtl/ssp_queue.sv
// ssp_queue: short word queue between the front and back parts
// depends on ssp_pkg
`default_nettype none

module ssp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ssp_pkg::proj_t wdata,
  output logic               full,
  output logic               rvalid,
  input  wire logic          pop,
  output ssp_pkg::proj_t     rdata
);
  import ssp_pkg::*;

  proj_t mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic do_pop;

  assign full   = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign rvalid = count != '0;
  assign do_pop = pop && rvalid;
  assign rdata  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

### rtl/ssp_back.sv
// ssp_back: depth and centre dividers, size dividers and the clipping stage
// depends on ssp_pkg; takes words from ssp_queue
`default_nettype none

module ssp_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [ssp_pkg::CFG_BITS-1:0] screen_width,
  input  wire logic [ssp_pkg::CFG_BITS-1:0] screen_height,
  input  wire logic                     q_valid,
  input  wire ssp_pkg::proj_t           q_data,
  output logic                          pop,
  output logic                          done,
  output ssp_pkg::result_t              result
);
  import ssp_pkg::*;

  localparam int Q1        = 32;
  localparam int Q2        = 16;
  localparam int QS        = 16;
  localparam int DIV_STEPS = Q1 + 1;
  localparam int SZ_STEPS  = QS + 1;
  localparam int R1W       = SUM_W + DEPTH_SHIFT;
  localparam int CW1       = DET_W + Q1;
  localparam int N2W       = CFG_BITS - 1 + SUM_W + 1;
  localparam int CW2       = SUM_W + Q2 + 1;
  localparam int SRW       = CFG_BITS + QS;
  localparam int DSW       = 31;
  localparam int CW3       = DSW + QS;

  typedef struct packed {
    logic [R1W-1:0]   r1;
    logic [DET_W-1:0] d1;
    logic [Q1-1:0]    q1;
    logic             neg1;
    logic             ovf1;
    logic             dz;
    logic [N2W-1:0]   r2;
    logic [SUM_W-1:0] d2;
    logic [Q2-1:0]    q2;
    logic             neg2;
    logic             ovf2;
  } div_stage_t;

  typedef struct packed {
    logic [SRW-1:0]     rh;
    logic [SRW-1:0]     rw;
    logic [DSW-1:0]     d;
    logic [QS-1:0]      qh;
    logic [QS-1:0]      qw;
    logic               ovfh;
    logic               ovfw;
    logic               behind;
    logic signed [31:0] depth;
    logic signed [15:0] center;
  } size_stage_t;

  logic [CFG_BITS-2:0] half_w;

  // front of the back part
  logic             b0_v;
  logic             b0_det_neg, b0_ny_neg, b0_sum_neg, b0_dz;
  logic [DET_W-1:0] b0_det_mag;
  logic [SUM_W-1:0] b0_ny_mag;
  logic [SUM_W:0]   b0_sum_mag;
  logic signed [SUM_W:0] sum_c;

  div_stage_t ds [DIV_STEPS+1];
  div_stage_t dn [DIV_STEPS];
  logic       dv [DIV_STEPS+1];

  logic               pv;
  logic signed [31:0] p_depth, depth_c;
  logic               p_behind, behind_c;
  logic signed [15:0] p_center, center_c;

  size_stage_t ss [SZ_STEPS+1];
  size_stage_t sn [SZ_STEPS];
  logic        sv [SZ_STEPS+1];

  logic [CW1-1:0] t1;
  logic [CW2-1:0] t2;
  logic [CW3-1:0] t3;

  logic [15:0] sh, sw;
  logic signed [LIM_W-1:0] hh, h_s, w_s, top_s, bot_s, left_s, right_s;
  logic [1:0] clip_c;
  result_t res_c;

  assign half_w = screen_width[CFG_BITS-1:1];
  assign pop    = q_valid;
  assign sum_c  = (SUM_W + 1)'(q_data.numx) + (SUM_W + 1)'(q_data.numy);

  // sign and magnitude split
  always_ff @(posedge clk) begin
    if (rst) b0_v <= 1'b0;
    else b0_v <= q_valid;
  end

  always_ff @(posedge clk) begin
    b0_det_neg <= q_data.det[DET_W-1];
    b0_det_mag <= q_data.det[DET_W-1] ? DET_W'(-q_data.det) : DET_W'(q_data.det);
    b0_ny_neg  <= q_data.numy[SUM_W-1];
    b0_ny_mag  <= q_data.numy[SUM_W-1] ? SUM_W'(-q_data.numy) : SUM_W'(q_data.numy);
    b0_sum_neg <= sum_c[SUM_W];
    b0_sum_mag <= sum_c[SUM_W] ? (SUM_W + 1)'(-sum_c) : (SUM_W + 1)'(sum_c);
    b0_dz      <= q_data.det == '0;
  end

  // one depth quotient bit per stage, centre quotient bits only up to stage Q2; first stage only flags overflow
  always_comb begin
    t1 = '0;
    t2 = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      dn[k] = ds[k];
      if (k == 0) begin
        dn[k].ovf1 = CW1'(ds[k].r1) >= {ds[k].d1, {Q1{1'b0}}};
        dn[k].ovf2 = CW2'(ds[k].r2) >= CW2'({ds[k].d2, {Q2{1'b0}}});
      end else begin
        t1 = CW1'(ds[k].d1) << (Q1 - k);
        if (CW1'(ds[k].r1) >= t1) begin
          dn[k].r1 = ds[k].r1 - R1W'(t1);
          dn[k].q1[Q1-k] = 1'b1;
        end
        if (k <= Q2) begin
          t2 = CW2'(ds[k].d2) << (Q2 - k);
          if (CW2'(ds[k].r2) >= t2) begin
            dn[k].r2 = ds[k].r2 - N2W'(t2);
            dn[k].q2[Q2-k] = 1'b1;
          end
        end
      end
    end
  end

  // divider stage 0 load, centre numerator product, then the divider stages
  always_ff @(posedge clk) begin
    ds[0].r1   <= {b0_ny_mag, {DEPTH_SHIFT{1'b0}}};
    ds[0].d1   <= b0_det_mag;
    ds[0].q1   <= '0;
    ds[0].neg1 <= b0_ny_neg ^ b0_det_neg;
    ds[0].ovf1 <= 1'b0;
    ds[0].dz   <= b0_dz;
    ds[0].r2   <= N2W'(half_w) * N2W'(b0_sum_mag);
    ds[0].d2   <= b0_ny_mag;
    ds[0].q2   <= '0;
    ds[0].neg2 <= b0_sum_neg ^ b0_ny_neg;
    ds[0].ovf2 <= 1'b0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      ds[k+1] <= dn[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_STEPS; k++) dv[k] <= 1'b0;
    end else begin
      dv[0] <= b0_v;
      for (int k = 0; k < DIV_STEPS; k++) dv[k+1] <= dv[k];
    end
  end

  // depth and centre saturation
  always_comb begin
    if (ds[DIV_STEPS].dz) begin
      depth_c = '0;
    end else if (!ds[DIV_STEPS].neg1) begin
      depth_c = (ds[DIV_STEPS].ovf1 || ds[DIV_STEPS].q1[Q1-1]) ? 32'sh7FFF_FFFF
                                                                : $signed(ds[DIV_STEPS].q1);
    end else begin
      depth_c = (ds[DIV_STEPS].ovf1 || ds[DIV_STEPS].q1 > 32'h8000_0000) ? 32'sh8000_0000
                                                                        : -$signed(ds[DIV_STEPS].q1);
    end
    behind_c = ds[DIV_STEPS].dz || depth_c[31] || depth_c == '0;
    if (behind_c) begin
      center_c = 16'(half_w);
    end else if (!ds[DIV_STEPS].neg2) begin
      center_c = (ds[DIV_STEPS].ovf2 || ds[DIV_STEPS].q2[Q2-1]) ? 16'sh7FFF
                                                                : $signed(ds[DIV_STEPS].q2);
    end else begin
      center_c = (ds[DIV_STEPS].ovf2 || ds[DIV_STEPS].q2 > 16'h8000) ? 16'sh8000
                                                                    : -$signed(ds[DIV_STEPS].q2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else pv <= dv[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    p_depth  <= depth_c;
    p_behind <= behind_c;
    p_center <= center_c;
  end

  // size dividers
  always_comb begin
    t3 = '0;
    for (int k = 0; k < SZ_STEPS; k++) begin
      sn[k] = ss[k];
      if (k == 0) begin
        sn[k].ovfh = CW3'(ss[k].rh) >= {ss[k].d, {QS{1'b0}}};
        sn[k].ovfw = CW3'(ss[k].rw) >= {ss[k].d, {QS{1'b0}}};
      end else begin
        t3 = CW3'(ss[k].d) << (QS - k);
        if (CW3'(ss[k].rh) >= t3) begin
          sn[k].rh = ss[k].rh - SRW'(t3);
          sn[k].qh[QS-k] = 1'b1;
        end
        if (CW3'(ss[k].rw) >= t3) begin
          sn[k].rw = ss[k].rw - SRW'(t3);
          sn[k].qw[QS-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ss[0].rh     <= {screen_height, {QS{1'b0}}};
    ss[0].rw     <= {screen_width, {QS{1'b0}}};
    ss[0].d      <= p_behind ? DSW'(1) : p_depth[DSW-1:0];
    ss[0].qh     <= '0;
    ss[0].qw     <= '0;
    ss[0].ovfh   <= 1'b0;
    ss[0].ovfw   <= 1'b0;
    ss[0].behind <= p_behind;
    ss[0].depth  <= p_depth;
    ss[0].center <= p_center;
    for (int k = 0; k < SZ_STEPS; k++) begin
      ss[k+1] <= sn[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SZ_STEPS; k++) sv[k] <= 1'b0;
    end else begin
      sv[0] <= pv;
      for (int k = 0; k < SZ_STEPS; k++) sv[k+1] <= sv[k];
    end
  end

  // limits and clipping
  always_comb begin
    sh = (ss[SZ_STEPS].behind || ss[SZ_STEPS].ovfh) ? 16'hFFFF : ss[SZ_STEPS].qh;
    sw = (ss[SZ_STEPS].behind || ss[SZ_STEPS].ovfw) ? 16'hFFFF : ss[SZ_STEPS].qw;
    hh  = LIM_W'(screen_height[CFG_BITS-1:1]);
    h_s = LIM_W'(screen_height);
    w_s = LIM_W'(screen_width);
    clip_c = '0;

    top_s = hh - LIM_W'(sh[15:1]);
    if (top_s < 0) top_s = '0;
    if (top_s > ROW_MAX) top_s = ROW_MAX;

    bot_s = LIM_W'(sh[15:1]) + hh;
    if (bot_s >= h_s) bot_s = h_s - LIM_W'(1);
    if (bot_s < 0) bot_s = '0;
    if (bot_s > ROW_MAX) bot_s = ROW_MAX;

    left_s = LIM_W'(ss[SZ_STEPS].center) - LIM_W'(sw[15:1]);
    if (left_s < 0) begin
      left_s = '0;
      clip_c = clip_c + 1'b1;
    end
    if (left_s > COL_MAX) left_s = COL_MAX;

    right_s = LIM_W'(sw[15:1]) + LIM_W'(ss[SZ_STEPS].center);
    if (right_s >= w_s) begin
      right_s = w_s;
      clip_c = clip_c + 1'b1;
    end
    if (right_s < 0) right_s = '0;
    if (right_s > COL_MAX) right_s = COL_MAX;

    res_c.depth         = ss[SZ_STEPS].depth;
    res_c.center_column = ss[SZ_STEPS].center;
    res_c.sprite_height = sh;
    res_c.sprite_width  = sw;
    res_c.top_row       = top_s[SCREEN_BITS-1:0];
    res_c.bottom_row    = bot_s[SCREEN_BITS-1:0];
    res_c.left_column   = left_s[SCREEN_BITS:0];
    res_c.right_column  = right_s[SCREEN_BITS:0];
    res_c.clipped_edges = clip_c;
    res_c.behind        = ss[SZ_STEPS].behind;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= sv[SZ_STEPS];
  end

  always_ff @(posedge clk) begin
    result <= res_c;
  end

endmodule

`default_nettype wire
